>>> sv/tpcs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the tuner port command sequencer.
// Depends on nothing; every other file of the block imports it.
package tpcs_pkg;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int FREQ_W   = 24;
    localparam int VOL_W    = 8;
    localparam int STATUS_W = 8;
    localparam int VALUE_W  = 8;
    localparam int DELAY_W  = 22;
    localparam int SIG_W    = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_FREQ   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_VOLUME = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INIT   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    // Port values
    localparam logic [VALUE_W-1:0] BASE_WORD     = 8'hD0;
    localparam logic [VALUE_W-1:0] MUTE_OFF      = 8'h08;
    localparam logic [VALUE_W-1:0] VAL_VOL_ZERO  = 8'h48;
    localparam logic [VALUE_W-1:0] VAL_VOL_UP    = 8'h98;
    localparam logic [VALUE_W-1:0] VAL_VOL_DOWN  = 8'h58;
    localparam logic [VALUE_W-1:0] VAL_VOL_STOP  = 8'hD8;
    localparam logic [VALUE_W-1:0] VAL_INIT      = 8'h90;
    localparam logic [VALUE_W-1:0] VAL_INIT_DONE = 8'hC0;
    localparam logic [VALUE_W-1:0] BIT_CLOCK     = 8'h01;
    localparam logic [VALUE_W-1:0] BIT_ONE       = 8'h04;
    localparam logic [VALUE_W-1:0] BIT_STROBE    = 8'h02;

    localparam logic [SIG_W-1:0] SIGNAL_TUNED = 16'hFFFF;
    localparam int STATUS_BUSY_BIT = 1;

    // Delays in microseconds
    localparam logic [DELAY_W-1:0] BIT_PAUSE_US  = 22'd1000;
    localparam logic [DELAY_W-1:0] INIT_PAUSE_US = 22'd3000000;
    localparam logic [11:0]        VOL_STEP_US   = 12'd3000;
    localparam int RAMP_W = VOL_W + 12;

    // Frequency word: (f + 171200) / 800 = ((f + 171200) >> 5) / 25.
    // The divide by 25 is a multiply by ceil(2^25 / 25) and a shift by 25,
    // exact for every dividend below 2^20.
    localparam int SUM_W   = FREQ_W + 1;
    localparam logic [SUM_W-1:0] FREQ_OFFSET = 25'd171200;
    localparam int DIVD_W  = SUM_W - 5;
    localparam int RECIP_W = 21;
    localparam logic [RECIP_W-1:0] RECIP_25 = 21'd1342178;
    localparam int RECIP_SHIFT = 25;
    localparam int PROD_W  = DIVD_W + RECIP_W;
    localparam int WORD_W  = 15;

    // Fixed trailer of the serial frame, first bit sent in bit 0
    localparam int TRAILER_LEN = 10;
    localparam logic [TRAILER_LEN-1:0] TRAILER = 10'b10_1000_0000;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        JOB_FREQ,
        JOB_MUTE,
        JOB_VOL,
        JOB_INIT,
        JOB_READ
    } job_kind_t;

    typedef struct packed {
        job_kind_t             kind;
        logic                  on;          // 1 when audio is not muted
        logic [WORD_W-1:0]     word;
        logic                  has_ramp;
        logic [VALUE_W-1:0]    ramp_value;
        logic [DELAY_W-1:0]    ramp_delay;
        logic                  tuned;
    } job_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

endpackage

>>> sv/tpcs_front.sv
`timescale 1ns / 1ps
// Front end: accepts commands, tracks the volume level and builds job records.
// Depends on tpcs_pkg.
module tpcs_front
    import tpcs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [CMD_W-1:0]    command,
    input  logic [FREQ_W-1:0]   frequency,
    input  logic                mute,
    input  logic [VOL_W-1:0]    volume,
    input  logic [STATUS_W-1:0] port_status,
    input  q_stat_t             q_stat,
    output logic                q_push,
    output job_t                q_data
);

    logic                s1_valid_reg, s1_valid_next;
    logic [CMD_W-1:0]    s1_cmd_reg;
    logic                s1_mute_reg;
    logic [DIVD_W-1:0]   s1_divd_reg;
    logic                s1_ramp_reg;
    logic [VALUE_W-1:0]  s1_ramp_value_reg;
    logic [VOL_W-1:0]    s1_diff_reg;
    logic                s1_tuned_reg;
    logic [VOL_W-1:0]    cur_vol_reg, cur_vol_next;

    logic                take;
    logic [SUM_W-1:0]    freq_sum;
    logic                ramp;
    logic [VALUE_W-1:0]  ramp_value;
    logic [VOL_W-1:0]    diff;
    logic [PROD_W-1:0]   quot_prod;
    logic [RAMP_W-1:0]   ramp_prod;

    assign full   = s1_valid_reg && q_stat.full;
    assign take   = push && !full;
    assign q_push = s1_valid_reg && !q_stat.full;

    assign freq_sum = SUM_W'(frequency) + FREQ_OFFSET;

    // Pick the ramp direction against the level left by the previous command
    always_comb
    begin
        ramp       = 1'b1;
        ramp_value = VAL_VOL_ZERO;
        diff       = cur_vol_reg;
        if (volume == '0)
        begin
            ramp_value = VAL_VOL_ZERO;
            diff       = cur_vol_reg;
        end
        else if (cur_vol_reg < volume)
        begin
            ramp_value = VAL_VOL_UP;
            diff       = volume - cur_vol_reg;
        end
        else if (cur_vol_reg > volume)
        begin
            ramp_value = VAL_VOL_DOWN;
            diff       = cur_vol_reg - volume;
        end
        else
        begin
            ramp = 1'b0;
            diff = '0;
        end
    end

    always_comb
    begin
        cur_vol_next = cur_vol_reg;
        if (take && command == CMD_VOLUME && !mute)
            cur_vol_next = volume;
        s1_valid_next = s1_valid_reg;
        if (take)
            s1_valid_next = 1'b1;
        else if (q_push)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            cur_vol_reg  <= '1;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            cur_vol_reg  <= cur_vol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_cmd_reg        <= command;
            s1_mute_reg       <= mute;
            s1_divd_reg       <= freq_sum[SUM_W-1:5];
            s1_ramp_reg       <= ramp;
            s1_ramp_value_reg <= ramp_value;
            s1_diff_reg       <= diff;
            s1_tuned_reg      <= !port_status[STATUS_BUSY_BIT];
        end
    end

    assign quot_prod = PROD_W'(s1_divd_reg) * PROD_W'(RECIP_25);
    assign ramp_prod = RAMP_W'(s1_diff_reg) * RAMP_W'(VOL_STEP_US);

    always_comb
    begin
        q_data            = '0;
        q_data.on         = !s1_mute_reg;
        q_data.word       = quot_prod[RECIP_SHIFT +: WORD_W];
        q_data.has_ramp   = s1_ramp_reg;
        q_data.ramp_value = s1_ramp_value_reg;
        q_data.ramp_delay = DELAY_W'(ramp_prod);
        q_data.tuned      = s1_tuned_reg;
        case (s1_cmd_reg)
            CMD_FREQ:   q_data.kind = JOB_FREQ;
            CMD_VOLUME: q_data.kind = s1_mute_reg ? JOB_MUTE : JOB_VOL;
            CMD_INIT:   q_data.kind = JOB_INIT;
            CMD_READ:   q_data.kind = JOB_READ;
            default:    q_data.kind = JOB_READ;
        endcase
    end

endmodule

>>> sv/tpcs_queue.sv
`timescale 1ns / 1ps
// Short job queue between the front end and the sequencer.
// Depends on tpcs_pkg.
module tpcs_queue
    import tpcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    wr_data,
    input  logic    pop,
    output q_stat_t stat,
    output job_t    rd_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t               entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign stat.valid = count_reg != '0;
    assign stat.full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign rd_data    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!stat.full || pop))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> stat.valid)
        else $error("job queue read while empty");

endmodule

>>> sv/tpcs_back.sv
`timescale 1ns / 1ps
// Sequencer: expands the job at the queue head into port writes, one per cycle
// while pop keeps up, into a one-entry result register. Depends on tpcs_pkg.
module tpcs_back
    import tpcs_pkg::*;
#(
    parameter int TUNE_BITS = 13
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  q_stat_t             q_stat,
    input  job_t                q_data,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output logic [VALUE_W-1:0]  port_value,
    output logic                writes_port,
    output logic [DELAY_W-1:0]  delay_us,
    output logic [SIG_W-1:0]    signal,
    output logic                last
);

    localparam int FRAME_BITS   = 1 + TUNE_BITS + TRAILER_LEN;
    localparam int FREQ_RESULTS = 2 * FRAME_BITS + 1;
    localparam int STEP_W       = $clog2(FREQ_RESULTS);
    localparam int BIT_IDX_W    = $clog2(FRAME_BITS);

    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]     value_reg;
    logic                   writes_reg;
    logic [DELAY_W-1:0]     delay_reg;
    logic [SIG_W-1:0]       signal_reg;
    logic                   last_reg;

    logic                   advance;
    logic [TUNE_BITS-1:0]   word_bits;
    logic [FRAME_BITS-1:0]  frame;
    logic [BIT_IDX_W-1:0]   bit_idx;
    logic                   half;
    logic                   closing;
    logic                   one;
    logic [VALUE_W-1:0]     on_value;
    logic [VALUE_W-1:0]     bit_value;
    logic [VALUE_W-1:0]     r_value;
    logic                   r_writes;
    logic [DELAY_W-1:0]     r_delay;
    logic [SIG_W-1:0]       r_signal;
    logic                   r_last;

    assign advance = q_stat.valid && (!out_valid_reg || pop);
    assign q_pop   = advance && r_last;

    // Frame: start bit, word bits LSB first, then the fixed trailer
    assign word_bits = TUNE_BITS'(q_data.word);
    assign frame     = {TRAILER, word_bits, 1'b0};
    assign bit_idx   = step_reg[BIT_IDX_W:1];
    assign half      = step_reg[0];
    assign closing   = step_reg == STEP_W'(FREQ_RESULTS - 1);
    assign one       = closing ? 1'b0 : frame[bit_idx];
    assign on_value  = q_data.on ? MUTE_OFF : '0;
    assign bit_value = BASE_WORD + on_value + BIT_CLOCK + (one ? BIT_ONE : '0)
                     + (half ? BIT_STROBE : '0);

    always_comb
    begin
        r_value  = '0;
        r_writes = 1'b1;
        r_delay  = '0;
        r_signal = '0;
        r_last   = 1'b1;
        case (q_data.kind)
            JOB_FREQ:
            begin
                r_value = closing ? BASE_WORD + on_value : bit_value;
                r_delay = (!closing && half) ? BIT_PAUSE_US : '0;
                r_last  = closing;
            end
            JOB_MUTE:
            begin
                r_value = BASE_WORD;
            end
            JOB_VOL:
            begin
                if (q_data.has_ramp && step_reg == '0)
                begin
                    r_value = q_data.ramp_value;
                    r_delay = q_data.ramp_delay;
                    r_last  = 1'b0;
                end
                else
                    r_value = VAL_VOL_STOP;
            end
            JOB_INIT:
            begin
                if (step_reg == '0)
                begin
                    r_value = VAL_INIT;
                    r_delay = INIT_PAUSE_US;
                    r_last  = 1'b0;
                end
                else
                    r_value = VAL_INIT_DONE;
            end
            JOB_READ:
            begin
                r_writes = 1'b0;
                r_signal = q_data.tuned ? SIGNAL_TUNED : '0;
            end
            default:
            begin
                r_writes = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (advance)
            step_next = r_last ? '0 : step_reg + 1'b1;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            value_reg  <= r_value;
            writes_reg <= r_writes;
            delay_reg  <= r_delay;
            signal_reg <= r_signal;
            last_reg   <= r_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign port_value  = value_reg;
    assign writes_port = writes_reg;
    assign delay_us    = delay_reg;
    assign signal      = signal_reg;
    assign last        = last_reg;

    a_step_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != '0 |-> q_stat.valid)
        else $error("sequencer mid-job with no job queued");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_W'(FREQ_RESULTS - 1))
        else $error("sequencer step beyond frame length");

endmodule

>>> sv/tuner_port_command_sequencer.sv
`timescale 1ns / 1ps
// Top level of the tuner port command sequencer.
// Depends on tpcs_pkg, tpcs_front, tpcs_queue and tpcs_back.

// Turns one tuner command per transfer into the stream of control-port
// writes it causes, each with the wait in microseconds that must follow it.
// Set frequency gives 2*(11+TUNE_BITS)+1 results (49 at the default): a
// serial frame of a start bit, TUNE_BITS bits of (frequency+171200)/800 LSB
// first and a fixed ten-bit trailer, two writes per bit, then a closing
// write. Set volume gives one or two results and, unless muted, remembers
// the new level (255 after reset); initialize gives two; read signal gives
// one result with writes_port low and the tuned status in signal. The last
// result of every command carries last. Both sides are queue-like: push a
// command while full is low, pop a result while empty is low. The
// sequencer gives one result per cycle while pop keeps up and so sets the
// sustained rate. The front end takes a new command in any cycle that its
// stage register can move on into the two-entry job queue, so up to two
// commands can wait behind the one being sequenced, and each command
// passes through the stage register and the job queue before its first
// result is registered.
module tuner_port_command_sequencer
    import tpcs_pkg::*;
#(
    parameter int TUNE_BITS = 13
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [CMD_W-1:0]    command,
    input  logic [FREQ_W-1:0]   frequency,
    input  logic                mute,
    input  logic [VOL_W-1:0]    volume,
    input  logic [STATUS_W-1:0] port_status,
    output logic                empty,
    input  logic                pop,
    output logic [VALUE_W-1:0]  port_value,
    output logic                writes_port,
    output logic [DELAY_W-1:0]  delay_us,
    output logic [SIG_W-1:0]    signal,
    output logic                last
);

    q_stat_t q_stat;
    logic    q_push;
    logic    q_pop;
    job_t    q_wr_data;
    job_t    q_rd_data;

    // Classify the command, hold the volume level, compute the tuning word
    tpcs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .frequency   (frequency),
        .mute        (mute),
        .volume      (volume),
        .port_status (port_status),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_data      (q_wr_data)
    );

    // Decouple the front end from the sequencer
    tpcs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .stat    (q_stat),
        .rd_data (q_rd_data)
    );

    // Expand the head job into port writes; drop it after its last result
    tpcs_back #(
        .TUNE_BITS (TUNE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .q_data      (q_rd_data),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .port_value  (port_value),
        .writes_port (writes_port),
        .delay_us    (delay_us),
        .signal      (signal),
        .last        (last)
    );

    a_read_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !writes_port) |-> (port_value == '0 && delay_us == '0 && last))
        else $error("status result carries port data");

    a_signal_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && writes_port) |-> signal == '0)
        else $error("port write carries a signal value");

endmodule
